/* rtl/imu_ma_pkg.sv */
// imu_ma_pkg: constants, payload structs, sequencer state and lane control
// struct shared by the imu moving average block; no dependencies
package imu_ma_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int WINDOW_LENGTH = 5;
  localparam int IMU_UNITS     = 4;
  localparam int AXES_PER_UNIT = 3;
  localparam int CHANNELS      = 12;
  localparam int ACTIVE_CH     = (IMU_UNITS * AXES_PER_UNIT > CHANNELS) ?
                                 CHANNELS : IMU_UNITS * AXES_PER_UNIT;

  localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
  localparam int SLOT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

  // signed window sum, and the reciprocal scale that keeps floor exact
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_LENGTH) + 1;
  localparam int RECIP_SH = SUM_W + 4;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [RECIP_W-1:0]         recip_t;

  typedef struct packed {
    sample_t imu1_roll;
    sample_t imu1_pitch;
    sample_t imu1_yaw;
    sample_t imu2_roll;
    sample_t imu2_pitch;
    sample_t imu2_yaw;
    sample_t imu3_roll;
    sample_t imu3_pitch;
    sample_t imu3_yaw;
    sample_t imu4_roll;
    sample_t imu4_pitch;
    sample_t imu4_yaw;
  } in_frame_t;

  typedef struct packed {
    sample_t avg1_roll;
    sample_t avg1_pitch;
    sample_t avg1_yaw;
    sample_t avg2_roll;
    sample_t avg2_pitch;
    sample_t avg2_yaw;
    sample_t avg3_roll;
    sample_t avg3_pitch;
    sample_t avg3_yaw;
    sample_t avg4_roll;
    sample_t avg4_pitch;
    sample_t avg4_yaw;
  } out_frame_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_MUL,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic [SLOT_W-1:0] wr_slot;
    logic              acc_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              mul_en;
    recip_t            recip;
  } lane_ctrl_t;

endpackage

/* rtl/imu_ma_in_if.sv */
// imu_ma_in_if: valid/ready channel carrying one imu frame
// depends on imu_ma_pkg
interface imu_ma_in_if import imu_ma_pkg::*; ();
  logic      valid;
  logic      ready;
  in_frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/imu_ma_out_if.sv */
// imu_ma_out_if: valid/ready channel carrying one frame of averages
// depends on imu_ma_pkg
interface imu_ma_out_if import imu_ma_pkg::*; ();
  logic       valid;
  logic       ready;
  out_frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/imu_ma_seq.sv */
// imu_ma_seq: shared sequencer; keeps fill count and write slot and steps
// all lanes through store, accumulate and scale; depends on imu_ma_pkg
module imu_ma_seq import imu_ma_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_free,
  output logic       load,
  output lane_ctrl_t ctrl
);

  seq_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] k_r, k_nxt;
  recip_t            recip_tab [WINDOW_LENGTH];

  // ceil(2^RECIP_SH / c) for every possible divisor
  for (genvar c = 1; c <= WINDOW_LENGTH; c++) begin : g_recip
    localparam recip_t RECIP_VAL =
      recip_t'(((64'd1 << RECIP_SH) + 64'(c) - 64'd1) / 64'(c));
    assign recip_tab[c-1] = RECIP_VAL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      slot_r  <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      slot_r  <= slot_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    slot_nxt     = slot_r;
    k_nxt        = k_r;
    in_ready     = 1'b0;
    load         = 1'b0;
    ctrl.start   = 1'b0;
    ctrl.wr_slot = slot_r;
    ctrl.acc_en  = 1'b0;
    ctrl.rd_slot = k_r;
    ctrl.mul_en  = 1'b0;
    ctrl.recip   = recip_tab[SLOT_W'(fill_r - CNT_W'(1))];
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.start = 1'b1;
          if (fill_r != CNT_W'(WINDOW_LENGTH)) begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          if (slot_r == SLOT_W'(WINDOW_LENGTH - 1)) begin
            slot_nxt = '0;
          end else begin
            slot_nxt = slot_r + SLOT_W'(1);
          end
          k_nxt     = '0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        ctrl.acc_en = 1'b1;
        if (CNT_W'(k_r) + CNT_W'(1) == fill_r) begin
          state_nxt = S_MUL;
        end else begin
          k_nxt = k_r + SLOT_W'(1);
        end
      end
      S_MUL: begin
        ctrl.mul_en = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        // hold the product until the output register is free
        if (out_free) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_SUM)
    else $error("accepted frame did not start accumulation");

  a_read_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUM |-> CNT_W'(k_r) < fill_r)
    else $error("accumulator read beyond filled slots");

  a_fill_nonzero_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> fill_r != '0 && fill_r <= CNT_W'(WINDOW_LENGTH))
    else $error("fill count out of range while busy");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free && state_r == S_OUT)
    else $error("result loaded while output register busy");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_W'(WINDOW_LENGTH - 1))
    else $error("write slot out of range");
`endif

endmodule

/* rtl/imu_ma_lane.sv */
// imu_ma_lane: one channel's sample history, window accumulator and
// reciprocal scaling to a truncated signed mean; depends on imu_ma_pkg
module imu_ma_lane import imu_ma_pkg::*; (
  input  logic       clk,
  input  lane_ctrl_t ctrl,
  input  sample_t    sample,
  output sample_t    mean
);

  sample_t                  hist_r [WINDOW_LENGTH];
  logic signed [SUM_W-1:0]  acc_r;
  logic [SUM_W-1:0]         mag;
  logic [PROD_W-1:0]        prod_r;
  logic                     neg_r;
  logic [SAMPLE_W-1:0]      qmag;

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      hist_r[ctrl.wr_slot] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + SUM_W'(hist_r[ctrl.rd_slot]);
    end
  end

  assign mag = acc_r[SUM_W-1] ? SUM_W'(-acc_r) : SUM_W'(acc_r);

  // floor(|sum| / count) as |sum| * ceil(2^sh / count) >> sh
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= PROD_W'(mag) * PROD_W'(ctrl.recip);
      neg_r  <= acc_r[SUM_W-1];
    end
  end

  assign qmag = prod_r[RECIP_SH +: SAMPLE_W];
  assign mean = neg_r ? sample_t'(-qmag) : sample_t'(qmag);

endmodule

/* rtl/imu_ma_merge.sv */
// imu_ma_merge: gathers the lane means into one result frame and holds it
// in the output register; depends on imu_ma_pkg and imu_ma_out_if
module imu_ma_merge import imu_ma_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sample_t              means [CHANNELS],
  output logic                 out_free,
  imu_ma_out_if.source         out_avg
);

  logic                         valid_r;
  out_frame_t                   data_r;
  logic [CHANNELS*SAMPLE_W-1:0] flat;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_pack
    assign flat[(CHANNELS-1-ch)*SAMPLE_W +: SAMPLE_W] = means[ch];
  end

  assign out_free = !valid_r || out_avg.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_avg.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= out_frame_t'(flat);
    end
  end

  assign out_avg.valid = valid_r;
  assign out_avg.data  = data_r;

endmodule

/* rtl/imu_moving_average.sv */
// imu_moving_average: top level; twelve channel lanes under one sequencer
// and an output merge register; depends on imu_ma_pkg, the channel
// interfaces, imu_ma_seq, imu_ma_lane and imu_ma_merge
//
// Takes one frame of twelve signed 16-bit angle samples per transaction and
// returns one frame with the moving average of each channel over its last
// five samples (fewer until five frames have arrived), truncated toward
// zero. Each frame passes in order through a store step, an accumulate
// step in which every lane's accumulator adds each of the n samples
// currently held (1 to 5), one history slot at a time, a reciprocal
// multiply and a load of the output register. A new frame is taken only
// after the last one is loaded, and the load waits while the output
// register stays full. Lanes of inactive IMU units report zero.
module imu_moving_average import imu_ma_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  imu_ma_in_if.sink    in_frame,
  imu_ma_out_if.source out_avg
);

  lane_ctrl_t                   ctrl;
  logic                         load;
  logic                         out_free;
  logic                         in_ready;
  sample_t                      means [CHANNELS];
  logic [CHANNELS*SAMPLE_W-1:0] in_flat;

  assign in_flat        = in_frame.data;
  assign in_frame.ready = in_ready;

  imu_ma_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_frame.valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .load     (load),
    .ctrl     (ctrl)
  );

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    if (ch < ACTIVE_CH) begin : g_active
      imu_ma_lane u_lane (
        .clk    (clk),
        .ctrl   (ctrl),
        .sample (sample_t'(in_flat[(CHANNELS-1-ch)*SAMPLE_W +: SAMPLE_W])),
        .mean   (means[ch])
      );
    end else begin : g_idle
      assign means[ch] = '0;
    end
  end

  imu_ma_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .means    (means),
    .out_free (out_free),
    .out_avg  (out_avg)
  );

endmodule
